### hdl/dwt_pkg.sv
// ----------------------------------------------------------------------------
// dwt_pkg
// Shared constants, opcodes and types for the data watchpoint table.
// ----------------------------------------------------------------------------
package dwt_pkg;

  localparam int MAX_WATCHES = 32;
  localparam int WIDX_W      = $clog2(MAX_WATCHES);
  localparam int CNT_W       = $clog2(MAX_WATCHES + 1);
  localparam int MEM_BYTES   = 256;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 8;
  localparam int OP_W        = 3;
  localparam int IN_W        = 24;
  localparam int OUT_W       = 32;

  localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
  localparam logic [OP_W-1:0] OP_SET       = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd4;
  localparam logic [OP_W-1:0] OP_REFRESH   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] snap;
    logic [ADDR_W-1:0] addr;
  } wt_entry_t;

  typedef struct packed {
    logic              ren;
    logic [MEM_AW-1:0] raddr;
    logic              wen;
    logic [MEM_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              ren;
    logic [WIDX_W-1:0] raddr;
    logic              wen;
    logic [WIDX_W-1:0] waddr;
    wt_entry_t         wdata;
  } wt_req_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] nv;
    logic [DATA_W-1:0] ov;
    logic [ADDR_W-1:0] ca;
    logic              ok;
  } result_t;

endpackage

### hdl/data_watchpoint_table_unit.sv
// ----------------------------------------------------------------------------
// data_watchpoint_table_unit
// Watch table of data-memory bytes with snapshot compare.
// Memory write, clear all, unused opcodes, set on a full table and clear on an
// empty one pass from S_START straight to S_DONE; set and clear scan the table
// until the address matches, check until a byte has changed and refresh over
// all entries, one table entry read per cycle through the table RAM read port.
// One request in flight at a time; the next is accepted in the cycle that tvalid
// rises, while the result waits. Reset (synchronous) empties the table and
// reads the memory copy as zero.
// ----------------------------------------------------------------------------
module data_watchpoint_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // opcode[2:0], address[10:3], write_value[18:11]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // success[0], changed_address[8:1],
                                     // old_value[16:9], new_value[24:17]
);
  import dwt_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  wt_req_t           wt_req;
  wt_entry_t         wt_rdata;
  result_t           out_res;

  dwt_mem_copy u_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  dwt_ram #(
    .WIDTH($bits(wt_entry_t)),
    .DEPTH(MAX_WATCHES)
  ) u_table (
    .clk  (clk),
    .wen  (wt_req.wen),
    .waddr(wt_req.waddr),
    .wdata(wt_req.wdata),
    .ren  (wt_req.ren),
    .raddr(wt_req.raddr),
    .rdata(wt_rdata)
  );

  dwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tdata[2:0]),
    .in_addr  (s_axis_tdata[10:3]),
    .in_val   (s_axis_tdata[18:11]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata),
    .wt_req   (wt_req),
    .wt_rdata (wt_rdata)
  );

  assign m_axis_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, out_res};

endmodule

### hdl/dwt_ram.sv
// ----------------------------------------------------------------------------
// dwt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/dwt_mem_copy.sv
// ----------------------------------------------------------------------------
// dwt_mem_copy
// Data memory copy: byte RAM plus per-byte valid bits so that it reads as
// zero after reset without a clearing pass.
// ----------------------------------------------------------------------------
module dwt_mem_copy (
  input  logic                      clk,
  input  logic                      rst,
  input  dwt_pkg::mem_req_t         req,
  output logic [dwt_pkg::DATA_W-1:0] rdata
);
  import dwt_pkg::*;

  logic [MEM_BYTES-1:0] valid;
  logic                 valid_q;
  logic [DATA_W-1:0]    ram_q;

  dwt_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEM_BYTES)
  ) u_ram (
    .clk  (clk),
    .wen  (req.wen),
    .waddr(req.waddr),
    .wdata(req.wdata),
    .ren  (req.ren),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.wen) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.ren) begin
        valid_q <= valid[req.raddr];
      end
    end
  end

  assign rdata = valid_q ? ram_q : '0;

endmodule

### hdl/dwt_ctrl.sv
// ----------------------------------------------------------------------------
// dwt_ctrl
// Request sequencer: decodes a request, walks the watch table through a
// two-stage read pipeline (table entry, then memory byte) and writes back.
// ----------------------------------------------------------------------------
module dwt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dwt_pkg::OP_W-1:0]   in_op,
  input  logic [dwt_pkg::ADDR_W-1:0] in_addr,
  input  logic [dwt_pkg::DATA_W-1:0] in_val,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dwt_pkg::result_t           out_res,
  output dwt_pkg::mem_req_t          mem_req,
  input  logic [dwt_pkg::DATA_W-1:0] mem_rdata,
  output dwt_pkg::wt_req_t           wt_req,
  input  dwt_pkg::wt_entry_t         wt_rdata
);
  import dwt_pkg::*;

  state_t            state, state_next;
  logic [OP_W-1:0]   req_op;
  logic [ADDR_W-1:0] req_addr;
  logic [DATA_W-1:0] req_val;
  logic [CNT_W-1:0]  count, count_next, cnt_m1;
  logic [CNT_W-1:0]  rd_idx;
  logic              s1_vld, s2_vld;
  logic [WIDX_W-1:0] s1_idx, s2_idx;
  wt_entry_t         s2_ent;
  wt_entry_t         last_ent;
  logic [DATA_W-1:0] set_snap;
  result_t           res, res_next;

  logic iss, hit1, hit2, end_scan, fin, start_scan, load_out, mem_scan;

  assign in_ready = (state == S_IDLE);
  assign cnt_m1   = count - CNT_W'(1);
  assign mem_scan = (req_op == OP_CHECK) || (req_op == OP_REFRESH);

  assign hit1 = (state == S_SCAN) && s1_vld &&
                ((req_op == OP_SET) || (req_op == OP_CLEAR)) &&
                (wt_rdata.addr == req_addr);
  assign hit2 = (state == S_SCAN) && s2_vld && (req_op == OP_CHECK) &&
                (mem_rdata != s2_ent.snap);
  assign end_scan = (state == S_SCAN) && (rd_idx == count) && !s1_vld && !s2_vld;
  assign fin      = hit1 || hit2 || end_scan;
  assign iss      = (state == S_SCAN) && (rd_idx < count) && !fin;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  assign start_scan = ((req_op == OP_SET) && (count < CNT_W'(MAX_WATCHES))) ||
                      ((req_op == OP_CLEAR) && (count != '0)) || mem_scan;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: state_next = start_scan ? S_SCAN : S_DONE;
      S_SCAN:  if (fin) state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory requests, result and count
  always_comb begin
    mem_req    = '0;
    wt_req     = '0;
    res_next   = res;
    count_next = count;
    case (state)
      S_IDLE: begin
        // prefetch the set snapshot and the last entry for a clear
        mem_req.ren   = 1'b1;
        mem_req.raddr = MEM_AW'(in_addr);
        wt_req.ren    = 1'b1;
        wt_req.raddr  = cnt_m1[WIDX_W-1:0];
      end
      S_START: begin
        res_next = '0;
        case (req_op)
          OP_WRITE: begin
            mem_req.wen   = 1'b1;
            mem_req.waddr = MEM_AW'(req_addr);
            mem_req.wdata = req_val;
            res_next.ok   = 1'b1;
          end
          OP_CLEAR_ALL: begin
            count_next  = '0;
            res_next.ok = 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (iss) begin
          wt_req.ren   = 1'b1;
          wt_req.raddr = rd_idx[WIDX_W-1:0];
        end
        if (s1_vld) begin
          mem_req.ren   = 1'b1;
          mem_req.raddr = MEM_AW'(wt_rdata.addr);
        end
        if (s2_vld && ((req_op == OP_REFRESH) || hit2)) begin
          wt_req.wen        = 1'b1;
          wt_req.waddr      = s2_idx;
          wt_req.wdata.addr = s2_ent.addr;
          wt_req.wdata.snap = mem_rdata;
        end
        if (hit2) begin
          res_next.ok = 1'b1;
          res_next.ca = s2_ent.addr;
          res_next.ov = s2_ent.snap;
          res_next.nv = mem_rdata;
        end
        if (hit1) begin
          res_next.ok = 1'b1;
          if (req_op == OP_CLEAR) begin
            // move the last entry into the freed slot
            wt_req.wen   = 1'b1;
            wt_req.waddr = s1_idx;
            wt_req.wdata = last_ent;
            count_next   = cnt_m1;
          end
        end
        if (end_scan) begin
          case (req_op)
            OP_SET: begin
              wt_req.wen        = 1'b1;
              wt_req.waddr      = count[WIDX_W-1:0];
              wt_req.wdata.addr = req_addr;
              wt_req.wdata.snap = set_snap;
              count_next        = count + CNT_W'(1);
              res_next.ok       = 1'b1;
            end
            OP_REFRESH: res_next.ok = 1'b1;
            default:    res_next.ok = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      s1_vld <= iss;
      s2_vld <= (state == S_SCAN) && s1_vld && mem_scan && !fin;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (state == S_IDLE && in_valid) begin
      req_op   <= in_op;
      req_addr <= in_addr;
      req_val  <= in_val;
    end
    if (state == S_START) begin
      set_snap <= mem_rdata;
      last_ent <= wt_rdata;
      rd_idx   <= '0;
    end else if (iss) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
    if (iss) begin
      s1_idx <= rd_idx[WIDX_W-1:0];
    end
    if (s1_vld) begin
      s2_idx <= s1_idx;
      s2_ent <= wt_rdata;
    end
    if (load_out) begin
      out_res <= res;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WATCHES))
    else $error("watch count above table size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!wt_req.wen && !mem_req.wen))
    else $error("memory write while idle");

  a_clear_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && req_op == OP_CLEAR) |-> (count != '0))
    else $error("clear scan on empty table");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result dropped while output stalled");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |=> (count == $past(count)))
    else $error("count changed outside a request");
`endif

endmodule
